// File: sv/rec_pkg.sv
// Shared types and constants for the RTT estimate cache.
// No dependencies; every other source file except rec_ram imports this package.
package rec_pkg;

   localparam int CACHE_ENTRIES = 16;
   localparam int RTT_GAIN_LOG  = 3;
   localparam int DEV_GAIN_LOG  = 2;

   localparam int ADDR_W  = 32;
   localparam int VAL_W   = 31;
   localparam int INDEX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

   localparam int RTT_ACC_W = VAL_W + RTT_GAIN_LOG + 1;
   localparam int DEV_ACC_W = VAL_W + DEV_GAIN_LOG + 1;

   localparam logic OP_ADD    = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   typedef logic [INDEX_W-1:0] index_type;

   typedef struct packed {
      logic [ADDR_W-1:0] tag;
      logic [VAL_W-1:0]  srtt;
      logic [VAL_W-1:0]  mdev;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic              wr_en;
      entry_type         wr_entry;
      logic              hit;
      logic [VAL_W-1:0]  srtt;
      logic [VAL_W-1:0]  mdev;
   } update_type;

   function automatic index_type slot_of(input logic [ADDR_W-1:0] addr);
      logic [15:0] low;
      low = addr[15:0];
      return INDEX_W'(low % 16'(CACHE_ENTRIES));
   endfunction

endpackage

// File: sv/rec_req_if.sv
// Request channel interface: valid/ready handshake with the request word.
// Depends on rec_pkg.
interface rec_req_if
   import rec_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              operation;
   logic [ADDR_W-1:0] address;
   logic [VAL_W-1:0]  rtt_sample;

   modport source (output valid, output operation, output address, output rtt_sample,
                   input ready);
   modport sink   (input valid, input operation, input address, input rtt_sample,
                   output ready);
endinterface

// File: sv/rec_rsp_if.sv
// Response channel interface: valid/ready handshake with the response word.
// Depends on rec_pkg.
interface rec_rsp_if
   import rec_pkg::*;
();
   logic             valid;
   logic             ready;
   logic             hit;
   logic [VAL_W-1:0] smoothed_rtt;
   logic [VAL_W-1:0] mean_deviation;

   modport source (output valid, output hit, output smoothed_rtt, output mean_deviation,
                   input ready);
   modport sink   (input valid, input hit, input smoothed_rtt, input mean_deviation,
                   output ready);
endinterface

// File: sv/rec_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rec_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// File: sv/rec_update.sv
// Slot update: tag match, rounded exponential averaging of SRTT and deviation.
// Depends on rec_pkg.
module rec_update
   import rec_pkg::*;
(
   input  entry_type         old_entry,
   input  logic              old_valid,
   input  logic              operation,
   input  logic [ADDR_W-1:0] address,
   input  logic [VAL_W-1:0]  rtt_sample,
   output update_type        upd
);
   logic [VAL_W-1:0]     old_srtt;
   logic [VAL_W-1:0]     old_mdev;
   logic                 addr_zero;
   logic                 match;
   logic [VAL_W-1:0]     err;
   logic [RTT_ACC_W-1:0] rtt_acc;
   logic [DEV_ACC_W-1:0] dev_acc;
   logic [VAL_W-1:0]     new_srtt;
   logic [VAL_W-1:0]     new_mdev;

   always_comb begin
      old_srtt  = old_valid ? old_entry.srtt : '0;
      old_mdev  = old_valid ? old_entry.mdev : '0;
      addr_zero = (address == '0);
      match     = old_valid && !addr_zero && (old_entry.tag == address);

      err = (rtt_sample > old_srtt) ? (rtt_sample - old_srtt) : (old_srtt - rtt_sample);

      rtt_acc = (RTT_ACC_W'(old_srtt) << RTT_GAIN_LOG) - RTT_ACC_W'(old_srtt)
              + RTT_ACC_W'(rtt_sample) + RTT_ACC_W'((1 << RTT_GAIN_LOG) >> 1);
      dev_acc = (DEV_ACC_W'(old_mdev) << DEV_GAIN_LOG) - DEV_ACC_W'(old_mdev)
              + DEV_ACC_W'(err) + DEV_ACC_W'((1 << DEV_GAIN_LOG) >> 1);
      new_srtt = rtt_acc[RTT_GAIN_LOG +: VAL_W];
      new_mdev = dev_acc[DEV_GAIN_LOG +: VAL_W];

      upd          = '0;
      upd.hit      = match;
      upd.wr_entry = old_entry;
      if (!addr_zero) begin
         if (operation == OP_ADD) begin
            upd.wr_en = 1'b1;
            if (match) begin
               upd.wr_entry.srtt = new_srtt;
               upd.wr_entry.mdev = new_mdev;
            end else begin
               upd.wr_entry.tag  = address;
               upd.wr_entry.srtt = rtt_sample;
               upd.wr_entry.mdev = '0;
            end
            upd.srtt = upd.wr_entry.srtt;
            upd.mdev = upd.wr_entry.mdev;
         end else if (match) begin
            upd.srtt = old_entry.srtt;
            upd.mdev = old_entry.mdev;
         end
      end
   end
endmodule

// File: sv/rtt_estimate_cache_unit.sv
// Top level of the RTT estimate cache: slot RAM, valid bits, sequencer, response register.
// Depends on rec_pkg, rec_req_if, rec_rsp_if, rec_ram, rec_update.
//
//   channel | dir | handshake          | word
//   --------+-----+--------------------+------------------------------------------
//   req_bus | in  | valid/ready        | operation, address, rtt_sample
//   rsp_bus | out | valid/ready        | hit, smoothed_rtt, mean_deviation
//
// Each word is accepted with its RAM read in S_IDLE, then updated, written back and
// loaded into the response register in S_CALC; the registered slot RAM read sets this split.
// Reset clears all per-slot valid bits together; there is no clearing pass.
// A held response stalls only the update cycle; a new word is accepted while
// the previous response waits.
module rtt_estimate_cache_unit
   import rec_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   rec_req_if.sink   req_bus,
   rec_rsp_if.source rsp_bus
);
   localparam logic S_IDLE = 1'b0;
   localparam logic S_CALC = 1'b1;

   logic                     state_ff, state_in;
   index_type                idx_ff, idx_in;
   logic                     op_ff, op_in;
   logic [ADDR_W-1:0]        addr_ff, addr_in;
   logic [VAL_W-1:0]         sample_ff, sample_in;
   logic [CACHE_ENTRIES-1:0] valid_ff, valid_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_hit_ff, rsp_hit_in;
   logic [VAL_W-1:0]         rsp_srtt_ff, rsp_srtt_in;
   logic [VAL_W-1:0]         rsp_mdev_ff, rsp_mdev_in;

   logic       accept;
   logic       advance;
   index_type  rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   entry_type  old_entry;
   update_type upd;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign advance       = (state_ff == S_CALC) && (!rsp_valid_ff || rsp_bus.ready);
   assign rd_addr       = (state_ff == S_CALC) ? idx_ff : slot_of(req_bus.address);
   assign old_entry     = entry_type'(rd_data);

   rec_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CACHE_ENTRIES)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (advance && upd.wr_en),
      .wr_addr (idx_ff),
      .wr_data (ENTRY_W'(upd.wr_entry)),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rec_update u_update (
      .old_entry  (old_entry),
      .old_valid  (valid_ff[idx_ff]),
      .operation  (op_ff),
      .address    (addr_ff),
      .rtt_sample (sample_ff),
      .upd        (upd)
   );

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      op_in        = op_ff;
      addr_in      = addr_ff;
      sample_in    = sample_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_srtt_in  = rsp_srtt_ff;
      rsp_mdev_in  = rsp_mdev_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               idx_in    = slot_of(req_bus.address);
               op_in     = req_bus.operation;
               addr_in   = req_bus.address;
               sample_in = req_bus.rtt_sample;
               state_in  = S_CALC;
            end
         end
         S_CALC: begin
            if (advance) begin
               if (upd.wr_en) begin
                  valid_in[idx_ff] = 1'b1;
               end
               rsp_valid_in = 1'b1;
               rsp_hit_in   = upd.hit;
               rsp_srtt_in  = upd.srtt;
               rsp_mdev_in  = upd.mdev;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      op_ff       <= op_in;
      addr_ff     <= addr_in;
      sample_ff   <= sample_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_srtt_ff <= rsp_srtt_in;
      rsp_mdev_ff <= rsp_mdev_in;
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.hit            = rsp_hit_ff;
   assign rsp_bus.smoothed_rtt   = rsp_srtt_ff;
   assign rsp_bus.mean_deviation = rsp_mdev_ff;
endmodule

// File: sv/rec_checker.sv
// Port-level checks for the RTT estimate cache, bound to the top level.
// Depends on rec_pkg and rtt_estimate_cache_unit.
module rec_checker
   import rec_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic             rsp_hit,
   input logic [VAL_W-1:0] rsp_srtt,
   input logic [VAL_W-1:0] rsp_mdev
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_srtt)
                                  && $stable(rsp_mdev))
      else $error("response word changed while stalled");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second word accepted while one is in flight");

   a_miss_no_dev: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_mdev == '0)
      else $error("miss reported nonzero deviation");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");
endmodule

bind rtt_estimate_cache_unit rec_checker u_rec_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_hit   (rsp_bus.hit),
   .rsp_srtt  (rsp_bus.smoothed_rtt),
   .rsp_mdev  (rsp_bus.mean_deviation)
);

// File: verif/rtt_estimate_cache_unit_checker.sv
// Scoreboard for the RTT estimate cache: mirrors the slot store, predicts each
// response word and compares it field by field with what the unit returns.
// Depends on rec_pkg, rec_req_if and rec_rsp_if.
module rtt_estimate_cache_unit_checker
   import rec_pkg::*;
(
   input  logic clock,
   input  logic reset,
   rec_req_if   req_mon,
   rec_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending,
   output int   add_count,
   output int   lookup_count,
   output int   hit_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic             hit;
      logic [VAL_W-1:0] srtt;
      logic [VAL_W-1:0] mdev;
   } estimate_type;

   logic [ADDR_W-1:0] tag_mirror  [CACHE_ENTRIES];
   logic [VAL_W-1:0]  srtt_mirror [CACHE_ENTRIES];
   logic [VAL_W-1:0]  mdev_mirror [CACHE_ENTRIES];
   estimate_type      expected_estimates [$];

   // rounded exponential average with gain 2^-lg, computed wide
   function automatic logic [VAL_W-1:0] ewma(input logic [VAL_W-1:0] prev,
                                             input logic [VAL_W-1:0] samp,
                                             input int lg);
      logic [63:0] acc;
      acc = ((64'd1 << lg) - 64'd1) * 64'(prev) + 64'(samp) + ((64'd1 << lg) >> 1);
      return VAL_W'(acc >> lg);
   endfunction

   function automatic estimate_type apply_word(input logic op,
                                               input logic [ADDR_W-1:0] addr,
                                               input logic [VAL_W-1:0] samp);
      int               slot;
      logic [VAL_W-1:0] prev;
      logic [VAL_W-1:0] err;
      estimate_type     est;
      est = '0;
      if (addr == '0) return est;
      slot = int'(addr[15:0]) % CACHE_ENTRIES;
      est.hit = (tag_mirror[slot] == addr);
      if (op == OP_ADD) begin
         if (est.hit) begin
            prev = srtt_mirror[slot];
            err = (samp > prev) ? samp - prev : prev - samp;
            srtt_mirror[slot] = ewma(prev, samp, RTT_GAIN_LOG);
            mdev_mirror[slot] = ewma(mdev_mirror[slot], err, DEV_GAIN_LOG);
         end else begin
            tag_mirror[slot]  = addr;
            srtt_mirror[slot] = samp;
            mdev_mirror[slot] = '0;
         end
      end
      if (est.hit || op == OP_ADD) begin
         est.srtt = srtt_mirror[slot];
         est.mdev = mdev_mirror[slot];
      end
      return est;
   endfunction

   always @(posedge clock) begin
      estimate_type want;
      int           errs;
      if (reset) begin
         foreach (tag_mirror[i]) begin
            tag_mirror[i]  = '0;
            srtt_mirror[i] = '0;
            mdev_mirror[i] = '0;
         end
         expected_estimates.delete();
         fail_count   <= 0;
         pending      <= 0;
         add_count    <= 0;
         lookup_count <= 0;
         hit_count    <= 0;
      end else begin
         errs = 0;
         if (req_mon.valid && req_mon.ready) begin
            want = apply_word(req_mon.operation, req_mon.address, req_mon.rtt_sample);
            expected_estimates.push_back(want);
            if (req_mon.operation == OP_ADD) add_count <= add_count + 1;
            else lookup_count <= lookup_count + 1;
            hit_count <= hit_count + int'(want.hit);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_estimates.size() == 0) begin
               $error("response word with no request outstanding");
               errs++;
            end else begin
               want = expected_estimates.pop_front();
               if (rsp_mon.hit !== want.hit) begin
                  $error("hit: expected %0d, actual %0d", want.hit, rsp_mon.hit);
                  errs++;
               end
               if (rsp_mon.smoothed_rtt !== want.srtt) begin
                  $error("smoothed_rtt: expected %0d, actual %0d",
                         want.srtt, rsp_mon.smoothed_rtt);
                  errs++;
               end
               if (rsp_mon.mean_deviation !== want.mdev) begin
                  $error("mean_deviation: expected %0d, actual %0d",
                         want.mdev, rsp_mon.mean_deviation);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
         pending    <= expected_estimates.size();
      end
   end

endmodule

// File: verif/rtt_estimate_cache_unit_tb.sv
// Top of the RTT estimate cache testbench: clock, reset, request stimulus,
// response back-pressure, watchdog and verdict.
// Depends on rec_pkg, both channel interfaces, the unit and its checker.
module rtt_estimate_cache_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rec_pkg::*;

   localparam int WORD_COUNT  = 2000;
   localparam int IDLE_PCT    = 19;
   localparam int POOL_SIZE   = 20;
   localparam int STALL_LIMIT = 1000;

   logic clock;
   logic reset;
   bit   pacing;
   int   quiet_cycles = 0;

   int fail_count;
   int pending;
   int add_count;
   int lookup_count;
   int hit_count;

   logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

   rec_req_if req_bus ();
   rec_rsp_if rsp_bus ();

   rtt_estimate_cache_unit uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   rtt_estimate_cache_unit_checker scoreboard (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_bus),
      .rsp_mon      (rsp_bus),
      .fail_count   (fail_count),
      .pending      (pending),
      .add_count    (add_count),
      .lookup_count (lookup_count),
      .hit_count    (hit_count)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == STALL_LIMIT) begin
            $display("[rtt_estimate_cache_unit] ERROR");
            $finish;
         end
      end
   end

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= !pacing || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   task automatic send_word(input logic op, input logic [ADDR_W-1:0] addr,
                            input logic [VAL_W-1:0] samp);
      while (pacing && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.operation  <= op;
      req_bus.address    <= addr;
      req_bus.rtt_sample <= samp;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   function automatic logic [VAL_W-1:0] pick_sample();
      int r;
      r = $urandom_range(99);
      if (r < 70) return VAL_W'($urandom_range(5000));
      if (r < 90) return VAL_W'($urandom);
      if (r < 95) return '0;
      return '1;
   endfunction

   initial begin
      int                r;
      logic [ADDR_W-1:0] addr;
      req_bus.valid      <= 1'b0;
      req_bus.operation  <= OP_ADD;
      req_bus.address    <= '0;
      req_bus.rtt_sample <= '0;
      reset              <= 1'b1;
      pacing = 1'b1;

      // a few addresses share low halves so their slots collide
      for (int i = 0; i < POOL_SIZE; i++) begin
         if (i < 12) addr_pool[i] = $urandom;
         else addr_pool[i] = {16'($urandom), addr_pool[i-12][15:0]};
         if (addr_pool[i] == '0) addr_pool[i] = 32'h1;
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_word(OP_LOOKUP, 32'h0000_0001, '0);
      send_word(OP_LOOKUP, '0, '1);
      send_word(OP_ADD,    '0, '1);
      send_word(OP_ADD,    32'hFFFF_FFFF, '1);
      send_word(OP_ADD,    32'hFFFF_FFFF, '0);
      send_word(OP_ADD,    32'hFFFF_FFFF, '1);
      send_word(OP_LOOKUP, 32'hFFFF_FFFF, '0);
      send_word(OP_ADD,    32'h0000_FFFF, 31'd100);
      send_word(OP_LOOKUP, 32'hFFFF_FFFF, '0);
      send_word(OP_ADD,    32'h8000_0000, '0);
      send_word(OP_ADD,    32'h8000_0000, '0);
      send_word(OP_ADD,    32'h8000_0000, 31'd1);
      send_word(OP_ADD,    32'h0000_0010, 31'd5);
      send_word(OP_LOOKUP, 32'h8000_0000, '0);
      send_word(OP_LOOKUP, 32'h0000_0010, '1);
      send_word(OP_ADD,    32'h1234_5678, 31'd1000);
      send_word(OP_ADD,    32'h1234_5678, 31'd1004);
      send_word(OP_ADD,    32'h1234_5678, 31'd996);
      send_word(OP_LOOKUP, 32'h1234_5678, '0);
      drain();

      for (int n = 0; n < WORD_COUNT; n++) begin
         pacing = !(n >= 600 && n < 1000);
         if (n == 1200) drain();
         r = $urandom_range(99);
         addr = addr_pool[$urandom_range(POOL_SIZE-1)];
         if (r < 55) send_word(OP_ADD, addr, pick_sample());
         else if (r < 85) send_word(OP_LOOKUP, addr, VAL_W'($urandom));
         else if (r < 90) send_word(1'($urandom), '0, pick_sample());
         else send_word(1'($urandom), ADDR_W'($urandom), pick_sample());
      end
      drain();
      repeat (8) @(posedge clock);

      $display("covered %0d adds and %0d lookups (%0d hits), with colliding slots,",
               add_count, lookup_count, hit_count);
      $display("address zero, extreme samples and back-pressure on both channels");
      if (fail_count == 0 && pending == 0) begin
         $display("[rtt_estimate_cache_unit] OK");
      end else begin
         $display("[rtt_estimate_cache_unit] ERROR");
      end
      $finish;
   end

endmodule

// File: sim.f
sv/rec_pkg.sv
sv/rec_req_if.sv
sv/rec_rsp_if.sv
sv/rec_ram.sv
sv/rec_update.sv
sv/rtt_estimate_cache_unit.sv
sv/rec_checker.sv
verif/rtt_estimate_cache_unit_checker.sv
verif/rtt_estimate_cache_unit_tb.sv
